[hw/rtl/bars_pkg.sv]
// Shared constants and types for the blank-aware running statistics unit.
package bars_pkg;

  localparam int MINMAX_W = 16;
  localparam int MEAN_W   = 24;
  localparam int RMS_W    = 24;
  localparam int TOTAL_W  = 24;
  localparam int QW       = 64;

  localparam logic signed [MEAN_W-1:0] MEAN_MAX = 24'sh7FFFFF;
  localparam logic signed [MEAN_W-1:0] MEAN_MIN = -24'sh800000;
  localparam logic [RMS_W-1:0]         RMS_MAX  = 24'hFFFFFF;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DMEAN = 8'b0000_0010,
    ST_MNS2  = 8'b0000_0100,
    ST_MS1SQ = 8'b0000_1000,
    ST_MNN1  = 8'b0001_0000,
    ST_DVAR  = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } back_st_t;

endpackage

[hw/rtl/bars_ifs.sv]
// Channel interfaces: sample input, configuration write and result output.
interface bars_in_if #(parameter int SB = 16);
  logic              valid;
  logic              ready;
  logic signed [SB-1:0] sample;
  logic              restart;
  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

interface bars_cfg_if #(parameter int SB = 16);
  logic              valid;
  logic              ready;
  logic signed [SB-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

interface bars_out_if import bars_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [MINMAX_W-1:0] min_value;
  logic signed [MINMAX_W-1:0] max_value;
  logic signed [MEAN_W-1:0]   mean_value;
  logic [RMS_W-1:0]           rms_value;
  logic                       stats_valid;
  logic                       rms_valid;
  logic [TOTAL_W-1:0]         blank_total;
  logic [TOTAL_W-1:0]         sample_total;
  logic                       count_overflow;
  modport source (output valid, min_value, max_value, mean_value, rms_value, stats_valid,
                  rms_valid, blank_total, sample_total, count_overflow, input ready);
  modport sink   (input valid, min_value, max_value, mean_value, rms_value, stats_valid,
                  rms_valid, blank_total, sample_total, count_overflow, output ready);
endinterface

[hw/rtl/bars_front.sv]
// Front end: takes samples, classifies blanks and keeps the running accumulators.
module bars_front import bars_pkg::*; #(
  parameter int SB = 16,
  parameter int CB = 24,
  localparam int SUMW = SB + CB,
  localparam int SQW  = 2*SB + CB,
  localparam int SNW  = 2*SB + SUMW + SQW + 3*CB + 1
) (
  input  logic           clk,
  input  logic           rst_n,
  bars_in_if.sink        in_port,
  bars_cfg_if.sink       cfg_port,
  output logic           push,
  input  logic           full,
  output logic [SNW-1:0] snap
);

  logic signed [SB-1:0]   blank_r;
  logic signed [SB-1:0]   min_r, max_r, min_b, max_b, min_nxt, max_nxt;
  logic signed [SUMW-1:0] sum_r, sum_b, sum_nxt;
  logic [SQW-1:0]         sq_r, sq_b, sq_nxt;
  logic [CB-1:0]          n_r, n_b, n_nxt, blk_r, blk_b, blk_nxt, tot_r, tot_b, tot_nxt;
  logic                   sat_r, sat_b, sat_nxt;
  logic signed [SB-1:0]   x;
  logic [SB-1:0]          mag;
  logic [2*SB-1:0]        sq;

  assign cfg_port.ready = 1'b1;
  assign in_port.ready  = !full;
  assign push           = in_port.valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r <= {1'b1, {(SB-1){1'b0}}};
    end else if (cfg_port.valid) begin
      blank_r <= cfg_port.data;
    end
  end

  always_comb begin
    x   = in_port.sample;
    mag = x[SB-1] ? (~x + 1'b1) : x;
    sq  = mag * mag;
    if (in_port.restart) begin
      min_b = '0; max_b = '0; sum_b = '0; sq_b = '0;
      n_b = '0; blk_b = '0; tot_b = '0; sat_b = 1'b0;
    end else begin
      min_b = min_r; max_b = max_r; sum_b = sum_r; sq_b = sq_r;
      n_b = n_r; blk_b = blk_r; tot_b = tot_r; sat_b = sat_r;
    end
    min_nxt = min_b; max_nxt = max_b; sum_nxt = sum_b; sq_nxt = sq_b;
    n_nxt = n_b; blk_nxt = blk_b; tot_nxt = tot_b; sat_nxt = sat_b;
    if (!sat_b) begin
      tot_nxt = tot_b + 1'b1;
      if (x == blank_r) begin
        blk_nxt = blk_b + 1'b1;
      end else begin
        if (n_b == '0) begin
          min_nxt = x;
          max_nxt = x;
        end else if (x > max_b) begin
          max_nxt = x;
        end else if (x < min_b) begin
          min_nxt = x;
        end
        sum_nxt = sum_b + {{CB{x[SB-1]}}, x};
        sq_nxt  = sq_b + SQW'(sq);
        n_nxt   = n_b + 1'b1;
      end
      sat_nxt = &tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0; max_r <= '0; sum_r <= '0; sq_r <= '0;
      n_r <= '0; blk_r <= '0; tot_r <= '0; sat_r <= 1'b0;
    end else if (push) begin
      min_r <= min_nxt; max_r <= max_nxt; sum_r <= sum_nxt; sq_r <= sq_nxt;
      n_r <= n_nxt; blk_r <= blk_nxt; tot_r <= tot_nxt; sat_r <= sat_nxt;
    end
  end

  assign snap = {sat_nxt, tot_nxt, blk_nxt, n_nxt, sq_nxt, sum_nxt, max_nxt, min_nxt};

endmodule

[hw/rtl/bars_fifo.sv]
// Two-entry queue of accumulator snapshots between front and back.
module bars_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] rd_data,
  output logic [1:0]   level
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign rd_data   = mem_r[rp_r];
  assign level     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

[hw/rtl/bars_back.sv]
// Back end: sequential mean, variance division and square root per snapshot.
module bars_back import bars_pkg::*; #(
  parameter int SB = 16,
  parameter int CB = 24,
  localparam int SUMW = SB + CB,
  localparam int SQW  = 2*SB + CB,
  localparam int SNW  = 2*SB + SUMW + SQW + 3*CB + 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           snap_valid,
  input  logic [SNW-1:0] snap,
  output logic           pop,
  bars_out_if.source     out_port
);

  localparam int PW   = SQW + CB;
  localparam int DW   = PW + 16;
  localparam int DVW  = 2*CB;
  localparam int MPW  = SUMW;
  localparam int CNTW = $clog2(DW + 1);

  back_st_t st_r, st_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic ov_r, fin_load;

  // snapshot fields
  logic signed [SB-1:0]   s_min, s_max;
  logic signed [SUMW-1:0] s_sum;
  logic [SQW-1:0]         s_sq;
  logic [CB-1:0]          s_n, s_blk, s_tot;
  logic                   s_sat;
  logic [SUMW-1:0]        s_mag;

  logic signed [SB-1:0]   min_r, max_r;
  logic signed [SUMW-1:0] s1_r;
  logic [SQW-1:0]         s2_r;
  logic [CB-1:0]          n_r, blk_r, tot_r;
  logic                   sat_r;
  logic [SUMW-1:0]        mag1;

  logic [PW-1:0]  mc_r, prod_r, ns2_r, diff_r, prod_n;
  logic [MPW-1:0] mp_r;
  logic [DW-1:0]  dd_r;
  logic [DVW-1:0] rem_r, dvs_r, rem_n;
  logic [DVW:0]   rem_s;
  logic           dge;
  logic [QW-1:0]  q_r, q_n, qm;
  logic signed [QW:0] mf;
  logic [QW-1:0]  v_r, res_r, bit_r, t_s, v_n, res_n;
  logic           sge;
  logic signed [MEAN_W-1:0] mean_r, mean_c;
  logic [RMS_W-1:0] rms_r;

  assign {s_sat, s_tot, s_blk, s_n, s_sq, s_sum, s_max, s_min} = snap;
  assign s_mag = s_sum[SUMW-1] ? (~s_sum + 1'b1) : s_sum;
  assign mag1  = s1_r[SUMW-1] ? (~s1_r + 1'b1) : s1_r;

  assign pop      = (st_r == ST_IDLE) && snap_valid;
  assign fin_load = (st_r == ST_FIN) && (!ov_r || out_port.ready);

  // shift-add multiplier step
  assign prod_n = prod_r + (mp_r[0] ? mc_r : '0);

  // restoring divider step
  always_comb begin
    rem_s = {rem_r, dd_r[DW-1]};
    dge   = rem_s >= {1'b0, dvs_r};
    rem_n = dge ? DVW'(rem_s - {1'b0, dvs_r}) : DVW'(rem_s);
    q_n   = {q_r[QW-2:0], dge};
  end

  // mean from the divider's final step, floored
  always_comb begin
    qm = q_n + QW'(s1_r[SUMW-1] && (rem_n != '0));
    mf = s1_r[SUMW-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    if (mf > (QW+1)'(MEAN_MAX))      mean_c = MEAN_MAX;
    else if (mf < (QW+1)'(MEAN_MIN)) mean_c = MEAN_MIN;
    else                             mean_c = MEAN_W'(mf);
  end

  // square root step, two bits a cycle
  always_comb begin
    t_s   = res_r + bit_r;
    sge   = v_r >= t_s;
    v_n   = sge ? v_r - t_s : v_r;
    res_n = sge ? (res_r >> 1) + bit_r : res_r >> 1;
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r - 1'b1;
    case (st_r)
      ST_IDLE: begin
        if (snap_valid) begin
          st_nxt  = (s_n != '0) ? ST_DMEAN : ST_FIN;
          cnt_nxt = CNTW'(DW - 1);
        end
      end
      ST_DMEAN: if (cnt_r == '0) begin
        st_nxt  = (n_r > CB'(1)) ? ST_MNS2 : ST_FIN;
        cnt_nxt = CNTW'(MPW - 1);
      end
      ST_MNS2: if (cnt_r == '0) begin
        st_nxt  = ST_MS1SQ;
        cnt_nxt = CNTW'(MPW - 1);
      end
      ST_MS1SQ: if (cnt_r == '0) begin
        st_nxt  = ST_MNN1;
        cnt_nxt = CNTW'(MPW - 1);
      end
      ST_MNN1: if (cnt_r == '0) begin
        st_nxt  = ST_DVAR;
        cnt_nxt = CNTW'(DW - 1);
      end
      ST_DVAR: if (cnt_r == '0) begin
        st_nxt  = ST_SQRT;
        cnt_nxt = CNTW'(QW/2 - 1);
      end
      ST_SQRT: if (cnt_r == '0) begin
        st_nxt = ST_FIN;
      end
      ST_FIN: if (fin_load) begin
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (fin_load)            ov_r <= 1'b1;
      else if (out_port.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (snap_valid) begin
          min_r <= s_min; max_r <= s_max; s1_r <= s_sum; s2_r <= s_sq;
          n_r <= s_n; blk_r <= s_blk; tot_r <= s_tot; sat_r <= s_sat;
          mean_r <= '0;
          rms_r  <= '0;
          dd_r   <= DW'({s_mag, 8'b0});
          rem_r  <= '0;
          dvs_r  <= DVW'(s_n);
          q_r    <= '0;
        end
      end
      ST_DMEAN: begin
        dd_r  <= dd_r << 1;
        rem_r <= rem_n;
        q_r   <= q_n;
        if (cnt_r == '0) begin
          mean_r <= mean_c;
          mc_r   <= PW'(s2_r);
          mp_r   <= MPW'(n_r);
          prod_r <= '0;
        end
      end
      ST_MNS2, ST_MS1SQ, ST_MNN1: begin
        prod_r <= prod_n;
        mc_r   <= mc_r << 1;
        mp_r   <= mp_r >> 1;
        if (cnt_r == '0) begin
          prod_r <= '0;
          if (st_r == ST_MNS2) begin
            ns2_r <= prod_n;
            mc_r  <= PW'(mag1);
            mp_r  <= mag1;
          end else if (st_r == ST_MS1SQ) begin
            diff_r <= ns2_r - prod_n;
            mc_r   <= PW'(n_r);
            mp_r   <= MPW'(n_r - 1'b1);
          end else begin
            dvs_r <= prod_n[DVW-1:0];
            dd_r  <= {diff_r, 16'b0};
            rem_r <= '0;
            q_r   <= '0;
          end
        end
      end
      ST_DVAR: begin
        dd_r  <= dd_r << 1;
        rem_r <= rem_n;
        q_r   <= q_n;
        if (cnt_r == '0) begin
          v_r   <= q_n;
          res_r <= '0;
          bit_r <= {2'b01, {(QW-2){1'b0}}};
        end
      end
      ST_SQRT: begin
        v_r   <= v_n;
        res_r <= res_n;
        bit_r <= bit_r >> 2;
        if (cnt_r == '0) begin
          rms_r <= (res_n > QW'(RMS_MAX)) ? RMS_MAX : RMS_W'(res_n);
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          out_port.min_value      <= MINMAX_W'(min_r);
          out_port.max_value      <= MINMAX_W'(max_r);
          out_port.mean_value     <= mean_r;
          out_port.rms_value      <= rms_r;
          out_port.stats_valid    <= n_r != '0;
          out_port.rms_valid      <= n_r > CB'(1);
          out_port.blank_total    <= TOTAL_W'(blk_r);
          out_port.sample_total   <= TOTAL_W'(tot_r);
          out_port.count_overflow <= sat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_port.valid = ov_r;

endmodule

[hw/rtl/blank_aware_running_statistics_unit.sv]
// Top level of the blank-aware running statistics unit.
// Usage:
//   in_port  : valid/ready channel, one signed sample plus a restart flag per word.
//   cfg_port : valid/ready write of the blank code; always ready. Write only when idle.
//   out_port : valid/ready channel, one result word per input word, in order.
// The front end updates min, max, sum, sum of squares and counts in the accepting
// cycle and queues a snapshot (two entries). The back end works one snapshot at a
// time with a shift-add multiplier, a restoring divider and a bitwise square root.
// The divider takes D = 2*SAMPLE_BITS+2*COUNT_BITS+16 steps (96 at defaults), the
// multiplier M = SAMPLE_BITS+COUNT_BITS steps (40). A word with no defined sample
// goes straight to the result; one defined sample needs the mean only; otherwise
// the mean, three multiplies, the variance division and the square root are run.
// The back end sets throughput; the front takes a word per cycle until the queue fills.
// Reset clears all statistics, sets the blank code to the most negative sample and
// empties the queue. A stalled receiver holds the result register; the back end
// finishes the next word behind it, then the queue fills and in_port.ready drops.
module blank_aware_running_statistics_unit import bars_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  bars_in_if.sink    in_port,
  bars_cfg_if.sink   cfg_port,
  bars_out_if.source out_port
);

  localparam int SNW = 2*SAMPLE_BITS + (SAMPLE_BITS + COUNT_BITS)
                     + (2*SAMPLE_BITS + COUNT_BITS) + 3*COUNT_BITS + 1;

  logic           push, full, pop, not_empty;
  logic [SNW-1:0] snap_in, snap_out;
  logic [1:0]     level;

  bars_front #(.SB(SAMPLE_BITS), .CB(COUNT_BITS)) u_front (
    .clk, .rst_n, .in_port, .cfg_port, .push, .full, .snap(snap_in)
  );

  bars_fifo #(.W(SNW)) u_fifo (
    .clk, .rst_n, .push, .wr_data(snap_in), .full, .pop, .not_empty,
    .rd_data(snap_out), .level
  );

  bars_back #(.SB(SAMPLE_BITS), .CB(COUNT_BITS)) u_back (
    .clk, .rst_n, .snap_valid(not_empty), .snap(snap_out), .pop, .out_port
  );

`ifndef SYNTHESIS
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    level != 2'd3) else $error("snapshot queue overrun");

  a_rms_needs_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_port.valid |-> (!out_port.rms_valid || out_port.stats_valid))
    else $error("rms valid without stats valid");

  a_overflow_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_port.valid && out_port.count_overflow |->
      out_port.sample_total == TOTAL_W'({COUNT_BITS{1'b1}}))
    else $error("overflow flag without saturated total");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> level == 2'd2) else $error("queue lost an entry");
`endif

endmodule

[verif/blank_aware_running_statistics_unit_tb.sv]
// Self-checking testbench for the blank-aware running statistics unit.
`timescale 1ns / 1ps

module blank_aware_running_statistics_unit_tb;
  import bars_pkg::*;

  typedef struct {
    logic signed [MINMAX_W-1:0] min_value;
    logic signed [MINMAX_W-1:0] max_value;
    logic signed [MEAN_W-1:0]   mean_value;
    logic [RMS_W-1:0]           rms_value;
    logic                       stats_valid;
    logic                       rms_valid;
    logic [TOTAL_W-1:0]         blank_total;
    logic [TOTAL_W-1:0]         sample_total;
    logic                       count_overflow;
  } stats_word_t;

  localparam longint COUNT_LIMIT = (64'd1 << TOTAL_W) - 1;

  logic clk;
  logic rst_n;

  bars_in_if  #(.SB(16)) in_if ();
  bars_cfg_if #(.SB(16)) cfg_if ();
  bars_out_if            out_if ();

  blank_aware_running_statistics_unit #(
    .SAMPLE_BITS(16),
    .COUNT_BITS (24)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_port (in_if),
    .cfg_port(cfg_if),
    .out_port(out_if)
  );

  // model state
  logic signed [15:0] blank_code_m;
  longint             run_lo;
  longint             run_hi;
  longint             run_total;
  bit [63:0]          run_squares;
  longint             n_defined;
  longint             n_blank;
  longint             n_seen;
  bit                 sat_flag;

  stats_word_t stats_q[$];
  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          n_restarts;
  int          n_blanks_sent;
  int          n_cfg_writes;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("Timeout at %0t with %0d words outstanding", $time, stats_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit [127:0] int_root(bit [127:0] v);
    bit [127:0] res;
    bit [127:0] t;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      t = res | (128'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic void clear_model();
    run_lo      = 0;
    run_hi      = 0;
    run_total   = 0;
    run_squares = '0;
    n_defined   = 0;
    n_blank     = 0;
    n_seen      = 0;
    sat_flag    = 1'b0;
  endfunction

  // Advances the running statistics by one word and queues the expected result.
  function automatic void accumulate_stats(logic signed [15:0] s, bit rs);
    stats_word_t w;
    longint      x;
    longint      avg;
    longint      mag;
    bit [127:0]  num;
    bit [127:0]  den;
    bit [127:0]  root;
    if (rs) clear_model();
    if (!sat_flag) begin
      n_seen++;
      if (s === blank_code_m) begin
        n_blank++;
      end else begin
        x = s;
        if (n_defined == 0) begin
          run_lo = x;
          run_hi = x;
        end else if (x > run_hi) begin
          run_hi = x;
        end else if (x < run_lo) begin
          run_lo = x;
        end
        run_total   += x;
        run_squares += 64'(x * x);
        n_defined++;
      end
      if (n_seen >= COUNT_LIMIT) sat_flag = 1'b1;
    end
    avg = 0;
    if (n_defined != 0) begin
      if (run_total >= 0) avg = (run_total * 256) / n_defined;
      else avg = -(((-run_total) * 256 + n_defined - 1) / n_defined);
      if (avg > 8388607) avg = 8388607;
      if (avg < -8388608) avg = -8388608;
    end
    w.rms_value = '0;
    if (n_defined >= 2) begin
      mag  = (run_total < 0) ? -run_total : run_total;
      num  = 128'(n_defined) * 128'(run_squares) - 128'(mag) * 128'(mag);
      num  = num << 16;
      den  = 128'(n_defined) * 128'(n_defined - 1);
      root = int_root(num / den);
      w.rms_value = (root > 128'hFFFFFF) ? RMS_MAX : root[RMS_W-1:0];
    end
    w.min_value      = run_lo[15:0];
    w.max_value      = run_hi[15:0];
    w.mean_value     = avg[MEAN_W-1:0];
    w.stats_valid    = (n_defined >= 1);
    w.rms_valid      = (n_defined >= 2);
    w.blank_total    = n_blank[TOTAL_W-1:0];
    w.sample_total   = n_seen[TOTAL_W-1:0];
    w.count_overflow = sat_flag;
    stats_q.push_back(w);
  endfunction

  // receiver: stall pattern switches among always-ready, random and burst-hold modes
  int unsigned rx_cycle;
  int unsigned rx_mode;
  int unsigned rx_hold;

  always @(negedge clk) begin
    if (!rst_n) begin
      rx_cycle <= 0;
      rx_mode  <= 0;
      rx_hold  <= 0;
      out_if.ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 200 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        default: begin
          if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            out_if.ready <= 1'b0;
          end else begin
            rx_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            out_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      n_errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    stats_word_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (stats_q.size() == 0) begin
        n_errors++;
        $display("%0t: result word with nothing expected", $time);
      end else begin
        e = stats_q.pop_front();
        n_checked++;
        check_field("min_value", e.min_value, out_if.min_value);
        check_field("max_value", e.max_value, out_if.max_value);
        check_field("mean_value", e.mean_value, out_if.mean_value);
        check_field("rms_value", e.rms_value, out_if.rms_value);
        check_field("stats_valid", e.stats_valid, out_if.stats_valid);
        check_field("rms_valid", e.rms_valid, out_if.rms_valid);
        check_field("blank_total", e.blank_total, out_if.blank_total);
        check_field("sample_total", e.sample_total, out_if.sample_total);
        check_field("count_overflow", e.count_overflow, out_if.count_overflow);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_sample(logic signed [15:0] s, bit rs);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.sample  <= s;
    in_if.restart <= rs;
    do @(posedge clk); while (!in_if.ready);
    accumulate_stats(s, rs);
    n_sent++;
    if (rs) n_restarts++;
    if (s === blank_code_m) n_blanks_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (stats_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_blank_code(logic signed [15:0] code);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= code;
    do @(posedge clk); while (!cfg_if.ready);
    blank_code_m = code;
    n_cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_sample(-16'sd32768, 1'b0);  // blank at reset code, nothing defined yet
    send_sample(16'sd32767, 1'b0);   // single defined sample
    send_sample(-16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd5, 1'b1);       // restart mid stream
    send_sample(16'sd5, 1'b0);       // equal values, zero deviation
    send_sample(-16'sd1, 1'b1);
    send_sample(-16'sd2, 1'b0);      // negative mean, exact
    send_sample(16'sd0, 1'b0);       // negative mean, still exact
    send_sample(-16'sd32768, 1'b1);  // restart on a blank
    send_sample(-16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b0);
    drain();
  endtask

  task automatic test_blank_codes();
    logic signed [15:0] codes[4];
    codes = '{16'sd32767, 16'sd0, -16'sd1, -16'sd32768};
    foreach (codes[i]) begin
      write_blank_code(codes[i]);
      send_sample(codes[i], 1'b1);
      send_sample(codes[i] ^ 16'sd1, 1'b0);
      send_sample(codes[i], 1'b0);
      send_sample(~codes[i], 1'b0);
      drain();
    end
  endtask

  task automatic test_random();
    logic signed [15:0] s;
    int unsigned pick;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 4) write_blank_code(16'sd32767);
      else write_blank_code(16'($urandom()));
      for (int k = 0; k < 300; k++) begin
        pick = $urandom_range(0, 15);
        case (pick)
          0, 1:    s = blank_code_m;
          2:       s = 16'sh7FFF;
          3:       s = 16'sh8000;
          4, 5, 6: s = 16'($urandom_range(0, 20) - 10);
          default: s = 16'($urandom());
        endcase
        send_sample(s, $urandom_range(0, 39) == 0);
      end
      drain();
    end
  endtask

  initial begin
    n_errors      = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_restarts    = 0;
    n_blanks_sent = 0;
    n_cfg_writes  = 0;
    burst_left    = 0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    in_if.restart = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    blank_code_m  = -16'sd32768;
    clear_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_blank_codes();
    test_random();

    drain();
    repeat (400) @(posedge clk);
    $display("Sent %0d words (%0d blank, %0d restarts), checked %0d results,",
             n_sent, n_blanks_sent, n_restarts, n_checked);
    $display("across %0d blank-code settings; %0d mismatches", n_cfg_writes, n_errors);
    if (n_errors == 0 && stats_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/bars_pkg.sv
hw/rtl/bars_ifs.sv
hw/rtl/bars_front.sv
hw/rtl/bars_fifo.sv
hw/rtl/bars_back.sv
hw/rtl/blank_aware_running_statistics_unit.sv
verif/blank_aware_running_statistics_unit_tb.sv
